// File: rtl/core/oakv_pkg.sv
`default_nettype none
package oakv_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int CFG_W       = 9;
  localparam int FUNC_W      = 3;
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int DIV_STEPS   = KEY_W;
  localparam int DIVC_W      = $clog2(DIV_STEPS + 1);
  localparam int IN_W        = 136;
  localparam int OUT_W       = 80;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(TABLE_SLOTS);

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ERASE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic probe_start;
    logic probe_run;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic probe_op;
    logic hit;
    logic miss;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/core/oakv_ctrl.sv
`default_nettype none
module oakv_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  oakv_pkg::dp_status_t   status_i,
  output oakv_pkg::ctrl_cmd_t    cmd_o
);
  import oakv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.probe_start = 1'b1;
          state_d = status_i.probe_op ? ST_PROBE : ST_EXEC;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_PROBE: begin
        if (status_i.hit || status_i.miss) begin
          if (status_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.probe_run = 1'b1;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/oakv_dp.sv
`default_nettype none
module oakv_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [oakv_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire  [oakv_pkg::FUNC_W-1:0]      in_func_i,
  input  wire  [oakv_pkg::KEY_W-1:0]       in_key_i,
  input  wire  [oakv_pkg::VAL_W-1:0]       in_value_i,
  input  oakv_pkg::ctrl_cmd_t              cmd_i,
  output oakv_pkg::dp_status_t             status_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             out_ok_o,
  output logic [oakv_pkg::VAL_W-1:0]       out_found_o,
  output logic [oakv_pkg::CNT_W-1:0]       out_count_o
);
  import oakv_pkg::*;

  // config and active slot count
  logic [CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0] n_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(cfg_q) > TABLE_SLOTS) begin
      n_act = CNT_W'(TABLE_SLOTS);
    end else begin
      n_act = CNT_W'(cfg_q);
    end
  end

  // latched beat
  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_func_i;
      key_q  <= in_key_i;
      val_q  <= in_value_i;
    end
  end

  logic put_op, probe_op;
  assign put_op   = (func_q == FUNC_INSERT) || (func_q == FUNC_SET);
  assign probe_op = put_op || (func_q == FUNC_GET) || (func_q == FUNC_ERASE);

  // restoring remainder, one key bit per step
  logic [KEY_W-1:0]  divsh_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DIVC_W-1:0] divc_q;
  logic [CNT_W:0]    trial;

  assign trial = {rem_q, divsh_q[KEY_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divc_q <= '0;
    end else if (cmd_i.accept) begin
      divc_q <= '0;
    end else if (cmd_i.div_step) begin
      divc_q <= divc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      divsh_q <= in_key_i;
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      divsh_q <= {divsh_q[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, n_act}) begin
        rem_q <= CNT_W'(trial - {1'b0, n_act});
      end else begin
        rem_q <= CNT_W'(trial);
      end
    end
  end

  // probe order generator
  logic [SLOT_W-1:0] home_q;
  logic [CNT_W-1:0]  dist_q;
  logic              lower_q;
  logic              gen_done;
  logic [CNT_W:0]    up_sum;
  logic              cand_ok;
  logic [SLOT_W-1:0] cand_slot;

  assign gen_done = (dist_q == n_act);
  assign up_sum   = (CNT_W+1)'(home_q) + (CNT_W+1)'(dist_q);

  always_comb begin
    if (lower_q) begin
      cand_slot = home_q - SLOT_W'(dist_q);
      cand_ok   = (dist_q != '0) && (dist_q <= CNT_W'(home_q));
    end else begin
      cand_slot = SLOT_W'(up_sum);
      cand_ok   = up_sum < (CNT_W+1)'(n_act);
    end
    if (gen_done) begin
      cand_ok = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= '0;
      lower_q <= 1'b0;
    end else if (cmd_i.probe_start) begin
      dist_q  <= '0;
      lower_q <= 1'b0;
    end else if (cmd_i.probe_run && !gen_done) begin
      lower_q <= !lower_q;
      if (lower_q) begin
        dist_q <= dist_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_start) begin
      home_q <= SLOT_W'(rem_q);
    end
  end

  // slot store: valid flags in flops, key/value in RAM
  logic [TABLE_SLOTS-1:0] valid_q;
  logic [KEY_W+VAL_W-1:0] mem [TABLE_SLOTS];
  logic [KEY_W+VAL_W-1:0] rd_q;
  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_wa;
  logic [KEY_W+VAL_W-1:0] mem_wd;

  // read data held while a hit waits for the output register
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.probe_run) begin
      rd_q <= mem[cand_slot];
    end
  end

  // compare stage
  logic              b_cand_q;
  logic              b_valid_q;
  logic [SLOT_W-1:0] b_slot_q;
  logic              hit;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;

  assign rd_key = rd_q[KEY_W+VAL_W-1:VAL_W];
  assign rd_val = rd_q[VAL_W-1:0];
  assign hit    = b_cand_q && (b_valid_q ? (rd_key == key_q) : put_op);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_cand_q <= 1'b0;
    end else if (cmd_i.probe_start) begin
      b_cand_q <= 1'b0;
    end else if (cmd_i.probe_run) begin
      b_cand_q <= cand_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_run) begin
      b_valid_q <= valid_q[cand_slot];
      b_slot_q  <= cand_slot;
    end
  end

  // operation effect
  logic [CNT_W-1:0] count_q;
  logic             set_v, clr_v, clr_all, inc, dec, res_ok;
  logic [VAL_W-1:0] res_found;

  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = b_slot_q;
    mem_wd    = {key_q, val_q};
    set_v     = 1'b0;
    clr_v     = 1'b0;
    clr_all   = 1'b0;
    inc       = 1'b0;
    dec       = 1'b0;
    res_ok    = 1'b0;
    res_found = '0;
    case (func_q)
      FUNC_INSERT, FUNC_SET: begin
        if (hit) begin
          if (!b_valid_q) begin
            mem_we = 1'b1;
            set_v  = 1'b1;
            inc    = 1'b1;
            res_ok = 1'b1;
          end else if (func_q == FUNC_SET) begin
            mem_we = 1'b1;
            res_ok = 1'b1;
          end
        end
      end
      FUNC_GET: begin
        if (hit) begin
          res_ok    = 1'b1;
          res_found = rd_val;
        end
      end
      FUNC_ERASE: begin
        if (hit) begin
          clr_v  = 1'b1;
          dec    = count_q != '0;
          res_ok = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        clr_all = 1'b1;
        res_ok  = 1'b1;
      end
      default: res_ok = 1'b0;
    endcase
    if (!cmd_i.finish) begin
      mem_we  = 1'b0;
      set_v   = 1'b0;
      clr_v   = 1'b0;
      clr_all = 1'b0;
      inc     = 1'b0;
      dec     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      if (clr_all) begin
        valid_q <= '0;
        count_q <= '0;
      end else begin
        if (set_v) begin
          valid_q[b_slot_q] <= 1'b1;
        end
        if (clr_v) begin
          valid_q[b_slot_q] <= 1'b0;
        end
        if (inc) begin
          count_q <= count_q + 1'b1;
        end else if (dec) begin
          count_q <= count_q - 1'b1;
        end
      end
    end
  end

  // output register
  logic             out_valid_q;
  logic             out_ok_q;
  logic [VAL_W-1:0] out_found_q;
  logic [CNT_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_ok_q    <= res_ok;
      out_found_q <= res_found;
      if (clr_all) begin
        out_count_q <= '0;
      end else if (inc) begin
        out_count_q <= count_q + 1'b1;
      end else if (dec) begin
        out_count_q <= count_q - 1'b1;
      end else begin
        out_count_q <= count_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_found_o = out_found_q;
  assign out_count_o = out_count_q;

  assign status_o.div_done = (divc_q == DIVC_W'(DIV_STEPS));
  assign status_o.probe_op = probe_op;
  assign status_o.hit      = hit;
  assign status_o.miss     = gen_done && !b_cand_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

// File: rtl/core/open_addressing_key_value_table.sv
// Key/value table with outward linear probing over up to 256 slots.
// Input stream (s_axis): one beat per operation: func, key, value.
// Output stream (m_axis): one beat per operation: ok, found_value, entry_count.
// Config: cfg_we_i/cfg_wdata_i write the active slot count (0 acts as 1,
//   above 256 acts as 256); write only while the table is idle.
// Per beat: the beat is accepted, then the home slot (key mod N, bit-serial
//   remainder, one key bit per cycle) is computed and loaded, then the probe
//   runs. The probe issues one up/down candidate position per cycle off a
//   single RAM read port and checks it against the registered read data;
//   the result register is loaded last. Clear and unused codes skip the
//   probe and load the result register directly.
// One operation is in flight at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so the table goes idle again while
//   a result waits; a stalled receiver holds off only the next result.
// Reset: all slots empty, count 0, slot count register 256. No clearing pass:
//   valid flags are flops cleared by reset and by the clear operation.
`default_nettype none
module open_addressing_key_value_table (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [oakv_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] func, [66:3] key, [130:67] value, [135:131] zero
  input  wire  [oakv_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // [0] ok, [64:1] found_value, [73:65] entry_count, [79:74] zero
  output logic [oakv_pkg::OUT_W-1:0]      m_axis_tdata
);
  import oakv_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             out_ok;
  logic [VAL_W-1:0] out_found;
  logic [CNT_W-1:0] out_count;

  oakv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  oakv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tdata[FUNC_W-1:0]),
    .in_key_i    (s_axis_tdata[FUNC_W+KEY_W-1:FUNC_W]),
    .in_value_i  (s_axis_tdata[FUNC_W+KEY_W+VAL_W-1:FUNC_W+KEY_W]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (out_ok),
    .out_found_o (out_found),
    .out_count_o (out_count)
  );

  // pack result beat, zero fill to a byte boundary
  assign m_axis_tdata = {(OUT_W-1-VAL_W-CNT_W)'(0), out_count, out_found, out_ok};

endmodule
`default_nettype wire
